// ----- rtl/core/brl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line rasterizer package
// Shared widths, types and the control interface between controller and
// datapath.
// ----------------------------------------------------------------------------
package brl_pkg;

   localparam int COORD_BITS = 6;
   localparam int COLOR_BITS = 24;
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_pixel;
   } dp_status_type;

endpackage

// ----- rtl/core/brl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line datapath
// Holds the request, derives the stepping setup and advances the error
// term one pixel per step into the output register.
// ----------------------------------------------------------------------------
module brl_datapath (
   input  logic                  clock,
   input  brl_pkg::ctrl_cmd_type cmd,
   output brl_pkg::dp_status_type status,
   input  brl_pkg::coord_type    req_start_x,
   input  brl_pkg::coord_type    req_start_y,
   input  brl_pkg::coord_type    req_end_x,
   input  brl_pkg::coord_type    req_end_y,
   input  brl_pkg::color_type    req_color,
   output brl_pkg::coord_type    rsp_pixel_x,
   output brl_pkg::coord_type    rsp_pixel_y,
   output brl_pkg::color_type    rsp_pixel_color,
   output logic                  rsp_last
);
   import brl_pkg::*;

   coord_type ax_ff, ay_ff, bx_ff, by_ff;
   color_type color_ff;

   coord_type pos_ff, pos_in;
   coord_type minor_ff, minor_in;
   coord_type cnt_ff, cnt_in;
   coord_type dmaj_ff, dmaj_in;
   coord_type dmin_ff, dmin_in;
   logic      neg_ff, neg_in;
   logic      xmaj_ff, xmaj_in;
   err_type   err_ff, err_in;

   coord_type out_x_ff, out_y_ff;
   color_type out_color_ff;
   logic      out_last_ff;

   logic      bx_gt_ax, by_gt_ay, fwd;
   coord_type dx_abs, dy_abs;
   coord_type x0, y0, x1, y1, maj0, maj1, min0, min1;
   err_type   twice_dmin_new, twice_dmin, twice_dmaj;
   logic      err_pos;

   always_comb begin
      bx_gt_ax = bx_ff > ax_ff;
      by_gt_ay = by_ff > ay_ff;
      dx_abs   = bx_gt_ax ? bx_ff - ax_ff : ax_ff - bx_ff;
      dy_abs   = by_gt_ay ? by_ff - ay_ff : ay_ff - by_ff;
      xmaj_in  = dx_abs > dy_abs;
      fwd      = xmaj_in ? bx_gt_ax : by_gt_ay;
      x0       = fwd ? ax_ff : bx_ff;
      y0       = fwd ? ay_ff : by_ff;
      x1       = fwd ? bx_ff : ax_ff;
      y1       = fwd ? by_ff : ay_ff;
      maj0     = xmaj_in ? x0 : y0;
      maj1     = xmaj_in ? x1 : y1;
      min0     = xmaj_in ? y0 : x0;
      min1     = xmaj_in ? y1 : x1;
      dmaj_in  = maj1 - maj0;
      neg_in   = min1 < min0;
      dmin_in  = neg_in ? min0 - min1 : min1 - min0;
      twice_dmin_new = err_type'({2'b00, dmin_in, 1'b0});
   end

   always_comb begin
      twice_dmin = err_type'({2'b00, dmin_ff, 1'b0});
      twice_dmaj = err_type'({2'b00, dmaj_ff, 1'b0});
      err_pos    = !err_ff[ERR_BITS-1] && (err_ff != '0);
      pos_in     = pos_ff + coord_type'(1);
      cnt_in     = cnt_ff - coord_type'(1);
      if (err_pos) begin
         minor_in = neg_ff ? minor_ff - coord_type'(1) : minor_ff + coord_type'(1);
         err_in   = err_ff - twice_dmaj + twice_dmin;
      end else begin
         minor_in = minor_ff;
         err_in   = err_ff + twice_dmin;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff    <= req_start_x;
         ay_ff    <= req_start_y;
         bx_ff    <= req_end_x;
         by_ff    <= req_end_y;
         color_ff <= req_color;
      end
      if (cmd.setup) begin
         pos_ff   <= maj0;
         minor_ff <= min0;
         cnt_ff   <= dmaj_in;
         dmaj_ff  <= dmaj_in;
         dmin_ff  <= dmin_in;
         neg_ff   <= neg_in;
         xmaj_ff  <= xmaj_in;
         err_ff   <= twice_dmin_new - err_type'({3'b000, dmaj_in});
      end else if (cmd.step) begin
         pos_ff   <= pos_in;
         minor_ff <= minor_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
      if (cmd.step) begin
         out_x_ff     <= xmaj_ff ? pos_ff : minor_ff;
         out_y_ff     <= xmaj_ff ? minor_ff : pos_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= (cnt_ff == '0);
      end
   end

   assign status.last_pixel = (cnt_ff == '0);
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ----- rtl/core/brl_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line controller
// Sequences request capture, setup and pixel stepping, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module brl_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output brl_pkg::ctrl_cmd_type  cmd,
   input  brl_pkg::dp_status_type status
);
   import brl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (out_free) begin
               cmd.step     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last_pixel) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/bresenham_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Turns one line request into the ordered stream of its pixels.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_) carries two endpoints and a color; an item is
// taken when req_valid is high and req_stall is low. The block then emits
// the line's pixels on the result channel (rsp_), one item per pixel, in
// stepping order along the major axis, with rsp_last set on the final one.
// A line of major length d gives d + 1 pixels. The request is captured, the
// error term is set up, and the first step then loads the first pixel into
// the output register; further pixels follow one per cycle while the
// receiver does not stall, as the error loop advances one pixel per step.
// req_stall stays high from the request until the last pixel has entered
// the output register. When the receiver stalls, the output register holds
// its pixel and the stepping pauses. A synchronous reset returns the
// controller to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  brl_pkg::coord_type req_start_x,
   input  brl_pkg::coord_type req_start_y,
   input  brl_pkg::coord_type req_end_x,
   input  brl_pkg::coord_type req_end_y,
   input  brl_pkg::color_type req_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output brl_pkg::coord_type rsp_pixel_x,
   output brl_pkg::coord_type rsp_pixel_y,
   output brl_pkg::color_type rsp_pixel_color,
   output logic               rsp_last
);
   import brl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   brl_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   brl_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_color       (req_color),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- rtl/core/brl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line rasterizer checker
// Port-level assertions on the rasterizer's handshakes and sequencing.
// ----------------------------------------------------------------------------
module brl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input brl_pkg::coord_type rsp_pixel_x,
   input brl_pkg::coord_type rsp_pixel_y,
   input brl_pkg::color_type rsp_pixel_color,
   input logic               rsp_last
);
   import brl_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("Block not idle after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Request taken while a line was starting.");

   a_idle_holds_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (!rsp_valid || rsp_last))
      else $error("Idle with a pending pixel that is not the last of its line.");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("Result item dropped while stalled.");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
                                    $stable(rsp_pixel_color) && $stable(rsp_last)))
      else $error("Result item changed while stalled.");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last        (rsp_last)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line rasterizer testbench
// Sends line requests through the request channel and checks every pixel on
// the result channel against a line-stepping predictor. A short table covers
// single pixels, full spans, diagonals and steep or shallow slopes in both
// directions. Random lines follow, with idle bursts on both sides and one
// long output stall that backs the block up into its request channel.
// ----------------------------------------------------------------------------
module tb_top;
   import brl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_LINES   = 350;
   localparam int PRESSURE_AT    = 80;
   localparam int CALM_FROM      = 300;
   localparam int MAX_REPORTS    = 30;
   localparam int TABLE_ROWS     = 20;

   typedef struct {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pixel_type;

   typedef struct {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      color_type color;
      bit        typed;
      coord_type tx;
      coord_type ty;
   } line_type;

   logic      clock           = 1'b0;
   logic      reset           = 1'b1;
   logic      req_valid       = 1'b0;
   logic      req_stall;
   coord_type req_start_x     = '0;
   coord_type req_start_y     = '0;
   coord_type req_end_x       = '0;
   coord_type req_end_y       = '0;
   color_type req_color       = '0;
   logic      rsp_valid;
   logic      rsp_stall       = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   color_type rsp_pixel_color;
   logic      rsp_last;

   pixel_type pending_pixels[$];
   line_type  line_plans[$];
   pixel_type got_pixel;
   pixel_type want_pixel;
   line_type  taken_line;

   int  mismatches     = 0;
   int  lines_drawn    = 0;
   int  pixels_checked = 0;
   int  idle_cycles    = 0;
   bit  pressure_wanted = 1'b0;
   bit  pressure_done   = 1'b0;
   bit  calm            = 1'b0;

   wire req_taken = req_valid && !req_stall;
   wire rsp_taken = rsp_valid && !rsp_stall;

   // Single-pixel rows carry their pixel; the rest go through the predictor.
   line_type directed_lines [TABLE_ROWS] = '{
      '{6'd0,  6'd0,  6'd0,  6'd0,  24'h000000, 1'b1, 6'd0,  6'd0},
      '{6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF, 1'b1, 6'd63, 6'd63},
      '{6'd21, 6'd42, 6'd21, 6'd42, 24'hAAAAAA, 1'b1, 6'd21, 6'd42},
      '{6'd0,  6'd0,  6'd63, 6'd0,  24'h555555, 1'b0, 6'd0,  6'd0},
      '{6'd63, 6'd63, 6'd0,  6'd63, 24'hAAAAAA, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd0,  6'd0,  6'd63, 24'hFFFFFF, 1'b0, 6'd0,  6'd0},
      '{6'd63, 6'd63, 6'd63, 6'd0,  24'h000000, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd0,  6'd63, 6'd63, 24'h123456, 1'b0, 6'd0,  6'd0},
      '{6'd63, 6'd0,  6'd0,  6'd63, 24'hFEDCBA, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd63, 6'd63, 6'd0,  24'h0F0F0F, 1'b0, 6'd0,  6'd0},
      '{6'd5,  6'd5,  6'd8,  6'd8,  24'hF0F0F0, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd0,  6'd63, 6'd20, 24'h3C3C3C, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd40, 6'd63, 6'd3,  24'hC3C3C3, 1'b0, 6'd0,  6'd0},
      '{6'd10, 6'd0,  6'd30, 6'd63, 24'h5A5A5A, 1'b0, 6'd0,  6'd0},
      '{6'd50, 6'd63, 6'd3,  6'd0,  24'hA5A5A5, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd0,  6'd63, 6'd62, 24'h00FF00, 1'b0, 6'd0,  6'd0},
      '{6'd0,  6'd0,  6'd62, 6'd63, 24'hFF00FF, 1'b0, 6'd0,  6'd0},
      '{6'd7,  6'd7,  6'd8,  6'd7,  24'h0000FF, 1'b0, 6'd0,  6'd0},
      '{6'd7,  6'd7,  6'd7,  6'd8,  24'hFF0000, 1'b0, 6'd0,  6'd0},
      '{6'd8,  6'd7,  6'd7,  6'd7,  24'h800001, 1'b0, 6'd0,  6'd0}
   };

   bresenham_line_rasterizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic void rasterize_line(line_type ln);
      int        ax;
      int        ay;
      int        bx;
      int        by;
      int        dmaj;
      int        dmin;
      int        step;
      int        err;
      int        pos;
      int        minor;
      bit        x_major;
      pixel_type px;
      ax = ln.sx;
      ay = ln.sy;
      bx = ln.ex;
      by = ln.ey;
      x_major = ((bx > ax) ? bx - ax : ax - bx) > ((by > ay) ? by - ay : ay - by);
      if (x_major) begin
         if (bx > ax) begin
            pos = ax; minor = ay; dmaj = bx - ax; dmin = by - ay;
         end else begin
            pos = bx; minor = by; dmaj = ax - bx; dmin = ay - by;
         end
      end else begin
         if (by > ay) begin
            pos = ay; minor = ax; dmaj = by - ay; dmin = bx - ax;
         end else begin
            pos = by; minor = bx; dmaj = ay - by; dmin = ax - bx;
         end
      end
      step = 1;
      if (dmin < 0) begin
         step = -1;
         dmin = -dmin;
      end
      err = 2 * dmin - dmaj;
      for (int i = 0; i <= dmaj; i++) begin
         px.x     = coord_type'(x_major ? pos : minor);
         px.y     = coord_type'(x_major ? minor : pos);
         px.color = ln.color;
         px.last  = (i == dmaj);
         pending_pixels.push_back(px);
         if (err > 0) begin
            minor += step;
            err   -= 2 * dmaj;
         end
         err += 2 * dmin;
         pos++;
      end
   endfunction

   function automatic line_type random_line();
      line_type ln;
      int       kind;
      int       d;
      kind     = $urandom_range(0, 19);
      ln.sx    = coord_type'($urandom);
      ln.sy    = coord_type'($urandom);
      ln.ex    = coord_type'($urandom);
      ln.ey    = coord_type'($urandom);
      ln.color = color_type'($urandom);
      ln.typed = 1'b0;
      ln.tx    = '0;
      ln.ty    = '0;
      if (kind >= 11 && kind < 16) begin
         ln.ex = coord_type'(int'(ln.sx) + int'($urandom_range(0, 8)) - 4);
         ln.ey = coord_type'(int'(ln.sy) + int'($urandom_range(0, 8)) - 4);
      end else if (kind == 16) begin
         ln.ex = ln.sx;
      end else if (kind == 17) begin
         ln.ey = ln.sy;
      end else if (kind == 18) begin
         d     = $urandom_range(0, 63);
         ln.sx = coord_type'($urandom_range(0, 63 - d));
         ln.sy = coord_type'($urandom_range(0, 63 - d));
         ln.ex = coord_type'(int'(ln.sx) + d);
         ln.ey = coord_type'(int'(ln.sy) + d);
         if ($urandom_range(0, 1)) begin
            ln.sx = 6'd63 - ln.sx;
            ln.ex = 6'd63 - ln.ex;
         end
         if ($urandom_range(0, 1)) begin
            ln.sy = 6'd63 - ln.sy;
            ln.ey = 6'd63 - ln.ey;
         end
      end else if (kind == 19) begin
         ln.ex = ln.sx;
         ln.ey = ln.sy;
      end
      return ln;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb_top: mismatch on %s: got %0h, expected %0h at %0t", what, got, want,
                  $time);
   endtask

   task automatic drive_line(line_type ln);
      line_plans.push_back(ln);
      req_valid   <= 1'b1;
      req_start_x <= ln.sx;
      req_start_y <= ln.sy;
      req_end_x   <= ln.ex;
      req_end_y   <= ln.ey;
      req_color   <= ln.color;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            taken_line = line_plans.pop_front();
            lines_drawn++;
            if (taken_line.typed) begin
               want_pixel.x     = taken_line.tx;
               want_pixel.y     = taken_line.ty;
               want_pixel.color = taken_line.color;
               want_pixel.last  = 1'b1;
               pending_pixels.push_back(want_pixel);
            end else begin
               rasterize_line(taken_line);
            end
         end
         if (rsp_taken) begin
            got_pixel.x     = rsp_pixel_x;
            got_pixel.y     = rsp_pixel_y;
            got_pixel.color = rsp_pixel_color;
            got_pixel.last  = rsp_last;
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected pixel x", got_pixel.x, 0);
            end else begin
               want_pixel = pending_pixels.pop_front();
               pixels_checked++;
               if (got_pixel.x !== want_pixel.x)
                  report_mismatch("pixel_x", got_pixel.x, want_pixel.x);
               if (got_pixel.y !== want_pixel.y)
                  report_mismatch("pixel_y", got_pixel.y, want_pixel.y);
               if (got_pixel.color !== want_pixel.color)
                  report_mismatch("pixel_color", got_pixel.color, want_pixel.color);
               if (got_pixel.last !== want_pixel.last)
                  report_mismatch("last", got_pixel.last, want_pixel.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (req_taken || rsp_taken || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: watchdog expired at %0t", $time);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (pressure_wanted && !pressure_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall     <= 1'b0;
            pressure_done = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < TABLE_ROWS; i++)
         drive_line(directed_lines[i]);
      for (int n = 0; n < RANDOM_LINES; n++) begin
         if (n == PRESSURE_AT)
            pressure_wanted = 1'b1;
         if (n == CALM_FROM)
            calm = 1'b1;
         drive_line(random_line());
      end
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0 || line_plans.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch("pixels left over", pending_pixels.size(), 0);
      $display("tb_top: %0d lines drawn, %0d pixels checked, %0d mismatches", lines_drawn,
               pixels_checked, mismatches);
      $display("tb_top: covered single pixels, full spans, diagonals, both slopes and a long stall");
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
